// ----- sv/tprc_pkg.sv -----
// shared types and constants of the threshold promote recency cache
// no dependencies; used by the cell and the top level

package tprc_pkg;

   // configuration register indexes
   localparam int  CSR_INDEX_W   = 1;
   localparam int  CSR_DATA_W    = 16;
   localparam logic [CSR_INDEX_W-1:0] CSR_THRESHOLD = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CAPACITY  = 1'b1;

   localparam int  THRESHOLD_W = 16;
   localparam int  CAPACITY_W  = 5;
   localparam logic [THRESHOLD_W-1:0] THRESHOLD_RESET = 16'd2;
   localparam logic [CAPACITY_W-1:0]  CAPACITY_RESET  = 5'd16;

   // result field widths that do not follow the parameters
   localparam int  POSITION_W  = 4;
   localparam int  OCCUPANCY_W = 5;

   // input command codes
   localparam logic CMD_REQUEST = 1'b0;
   localparam logic CMD_CLEAR   = 1'b1;

   typedef enum logic [1:0] {
      S_IDLE   = 2'b01,
      S_UPDATE = 2'b10
   } tprc_state_type;

   // per-cell control from the sequencer
   typedef struct packed {
      logic match_en;
      logic shift_en;
      logic write_en;
   } tprc_cell_ctrl_type;

endpackage

// ----- sv/tprc_ifs.sv -----
// request and response channel interfaces of the recency cache
// no dependencies

interface tprc_req_if #(parameter int KEY_BITS = 32);
   logic                valid;
   logic                ready;
   logic                command;
   logic [KEY_BITS-1:0] key;

   modport source (output valid, command, key, input ready);
   modport sink   (input valid, command, key, output ready);
endinterface

interface tprc_rsp_if #(parameter int KEY_BITS = 32, parameter int COUNT_BITS = 16);
   logic                  valid;
   logic                  ready;
   logic                  hit;
   logic [COUNT_BITS-1:0] request_count;
   logic [3:0]            hit_position;
   logic                  promoted;
   logic                  evicted;
   logic [KEY_BITS-1:0]   evicted_key;
   logic [4:0]            occupancy;

   modport source (output valid, hit, request_count, hit_position, promoted, evicted,
                   evicted_key, occupancy, input ready);
   modport sink   (input valid, hit, request_count, hit_position, promoted, evicted,
                   evicted_key, occupancy, output ready);
endinterface

// ----- sv/tprc_cell.sv -----
// one list position: key, request count and match flag
// depends on tprc_pkg for the control struct

module tprc_cell import tprc_pkg::*; #(
   parameter int KEY_BITS   = 32,
   parameter int COUNT_BITS = 16
) (
   input  logic                  clock,
   input  tprc_cell_ctrl_type    ctrl,
   input  logic                  live,
   input  logic [KEY_BITS-1:0]   cmp_key,
   input  logic [KEY_BITS-1:0]   prev_key,
   input  logic [COUNT_BITS-1:0] prev_count,
   input  logic [COUNT_BITS-1:0] wr_count,
   output logic [KEY_BITS-1:0]   key_out,
   output logic [COUNT_BITS-1:0] count_out,
   output logic                  match_out
);

   logic [KEY_BITS-1:0]   key_ff;
   logic [COUNT_BITS-1:0] count_ff;
   logic                  match_ff;

   always_ff @(posedge clock) begin
      if (ctrl.match_en) begin
         match_ff <= live && (key_ff == cmp_key);
      end
      if (ctrl.shift_en) begin
         key_ff   <= prev_key;
         count_ff <= prev_count;
      end else if (ctrl.write_en) begin
         count_ff <= wr_count;
      end
   end

   assign key_out   = key_ff;
   assign count_out = count_ff;
   assign match_out = match_ff;

endmodule

// ----- sv/threshold_promote_recency_cache_top.sv -----
// top level of the threshold promote recency cache: sequencer, csr and cell row
// depends on tprc_pkg, tprc_ifs and tprc_cell
// a result is registered in the update step after its request transaction is accepted;
// that step waits while an earlier result is not yet taken. One transaction at a time:
// the registered key compare in the cell row, then the update and shift step of the row
// reset (synchronous, active high): list empty, threshold 2, capacity 16, no clearing pass

module threshold_promote_recency_cache_top import tprc_pkg::*; #(
   parameter int DEPTH      = 16,
   parameter int KEY_BITS   = 32,
   parameter int COUNT_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   tprc_req_if.sink               req_bus,
   tprc_rsp_if.source             rsp_bus,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int FILL_W = $clog2(DEPTH + 1);
   localparam int POS_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CMP_W  = (FILL_W > CAPACITY_W) ? FILL_W : CAPACITY_W;
   localparam int THR_W  = (COUNT_BITS > THRESHOLD_W) ? COUNT_BITS : THRESHOLD_W;

   // control and configuration
   tprc_state_type          state_ff, state_in;
   logic [FILL_W-1:0]       fill_ff, fill_in;
   logic [THRESHOLD_W-1:0]  threshold_ff;
   logic [CAPACITY_W-1:0]   capacity_ff;

   // captured request
   logic                    cmd_ff;
   logic [KEY_BITS-1:0]     key_ff;

   // result register
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    hit_ff;
   logic [COUNT_BITS-1:0]   count_ff;
   logic [POSITION_W-1:0]   position_ff;
   logic                    promoted_ff;
   logic                    evicted_ff;
   logic [KEY_BITS-1:0]     evicted_key_ff;
   logic [OCCUPANCY_W-1:0]  occupancy_ff;

   // cell row
   tprc_cell_ctrl_type      cell_ctrl [DEPTH];
   logic [KEY_BITS-1:0]     key_chain [DEPTH+1];
   logic [COUNT_BITS-1:0]   count_chain [DEPTH+1];
   logic [DEPTH-1:0]        live;
   logic [DEPTH-1:0]        match_vec;

   // update step
   logic                    accept;
   logic                    commit;
   logic                    hit_any;
   logic [POS_W-1:0]        pos;
   logic [POS_W+POSITION_W-1:0] pos_wide;
   logic [COUNT_BITS-1:0]   sel_count;
   logic [COUNT_BITS-1:0]   new_count;
   logic [KEY_BITS-1:0]     tail_key;
   logic                    promote;
   logic                    evict;
   logic [CMP_W-1:0]        fill_c, cap_c, depth_c, cap_eff;
   logic [FILL_W+OCCUPANCY_W-1:0] occ_wide;

   // handshake: one request at a time, result slot frees on rsp transaction
   assign accept        = req_bus.valid && req_bus.ready;
   assign req_bus.ready = (state_ff == S_IDLE);
   assign commit        = (state_ff == S_UPDATE) && (!rsp_valid_ff || rsp_bus.ready);

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THRESHOLD_RESET;
         capacity_ff  <= CAPACITY_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_THRESHOLD: threshold_ff <= csr_wdata[THRESHOLD_W-1:0];
            CSR_CAPACITY:  capacity_ff  <= csr_wdata[CAPACITY_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // selection from the one-hot match vector (keys in the list are unique)
   always_comb begin
      pos       = '0;
      sel_count = '0;
      tail_key  = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (match_vec[i]) begin
            pos       = pos | POS_W'(i);
            sel_count = sel_count | count_chain[i+1];
         end
         // tail entry sits at fill - 1
         if (FILL_W'(i + 1) == fill_ff) begin
            tail_key = tail_key | key_chain[i+1];
         end
      end
   end

   assign hit_any   = |match_vec;
   assign new_count = (sel_count == '1) ? sel_count : sel_count + COUNT_BITS'(1);
   assign promote   = hit_any && (THR_W'(new_count) > THR_W'(threshold_ff)) && (pos != '0);

   // capacity clamped into 1..DEPTH
   assign fill_c  = CMP_W'(fill_ff);
   assign cap_c   = CMP_W'(capacity_ff);
   assign depth_c = CMP_W'(DEPTH);
   assign cap_eff = (cap_c == '0) ? CMP_W'(1) : ((cap_c > depth_c) ? depth_c : cap_c);
   assign evict   = !hit_any && (fill_c >= cap_eff) && (fill_c != '0);

   // front of the row takes the promoted or new entry
   assign key_chain[0]   = key_ff;
   assign count_chain[0] = hit_any ? new_count : COUNT_BITS'(1);

   generate
      for (genvar g = 0; g < DEPTH; g++) begin : g_cell
         logic shift_sel;

         assign live[g] = (FILL_W'(g) < fill_ff);

         // promote shifts up to the hit; miss: cells 0..fill, or only live ones on evict
         always_comb begin
            if (hit_any) begin
               shift_sel = promote && (POS_W'(g) <= pos);
            end else if (evict) begin
               shift_sel = live[g];
            end else begin
               shift_sel = (FILL_W'(g) <= fill_ff);
            end
         end

         assign cell_ctrl[g].match_en = accept;
         assign cell_ctrl[g].shift_en = commit && (cmd_ff == CMD_REQUEST) && shift_sel;
         assign cell_ctrl[g].write_en = commit && (cmd_ff == CMD_REQUEST) && hit_any &&
                                        !promote && match_vec[g];

         tprc_cell #(
            .KEY_BITS   (KEY_BITS),
            .COUNT_BITS (COUNT_BITS)
         ) u_cell (
            .clock      (clock),
            .ctrl       (cell_ctrl[g]),
            .live       (live[g]),
            .cmp_key    (req_bus.key),
            .prev_key   (key_chain[g]),
            .prev_count (count_chain[g]),
            .wr_count   (new_count),
            .key_out    (key_chain[g+1]),
            .count_out  (count_chain[g+1]),
            .match_out  (match_vec[g])
         );
      end
   endgenerate

   // sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_UPDATE;
            end
         end
         S_UPDATE: begin
            if (commit) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // fill level after this transaction
   always_comb begin
      if (cmd_ff == CMD_CLEAR) begin
         fill_in = '0;
      end else if (hit_any || evict) begin
         fill_in = fill_ff;
      end else begin
         fill_in = fill_ff + FILL_W'(1);
      end
   end

   assign rsp_valid_in = commit ? 1'b1 : (rsp_valid_ff && !rsp_bus.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (commit) begin
            fill_ff <= fill_in;
         end
      end
   end

   // request capture
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff <= req_bus.command;
         key_ff <= req_bus.key;
      end
   end

   assign pos_wide = {{POSITION_W{1'b0}}, pos};
   assign occ_wide = {{OCCUPANCY_W{1'b0}}, fill_in};

   // result register; a clear reports all zeros
   always_ff @(posedge clock) begin
      if (commit) begin
         occupancy_ff <= occ_wide[OCCUPANCY_W-1:0];
         if (cmd_ff == CMD_CLEAR) begin
            hit_ff         <= 1'b0;
            count_ff       <= '0;
            position_ff    <= '0;
            promoted_ff    <= 1'b0;
            evicted_ff     <= 1'b0;
            evicted_key_ff <= '0;
         end else begin
            hit_ff         <= hit_any;
            count_ff       <= hit_any ? new_count : COUNT_BITS'(1);
            position_ff    <= hit_any ? pos_wide[POSITION_W-1:0] : '0;
            promoted_ff    <= promote;
            evicted_ff     <= evict;
            evicted_key_ff <= evict ? tail_key : '0;
         end
      end
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.hit           = hit_ff;
   assign rsp_bus.request_count = count_ff;
   assign rsp_bus.hit_position  = position_ff;
   assign rsp_bus.promoted      = promoted_ff;
   assign rsp_bus.evicted       = evicted_ff;
   assign rsp_bus.evicted_key   = evicted_key_ff;
   assign rsp_bus.occupancy     = occupancy_ff;

`ifndef SYNTH
   // the list never holds more than the row has cells
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(DEPTH))
      else $error("fill level beyond row depth");

   // keys in the list are unique, so at most one cell matches
   a_single_match: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_UPDATE) |-> $onehot0(match_vec))
      else $error("more than one cell matched the key");

   // an accepted request always moves the sequencer to its update step
   a_accept_update: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == S_UPDATE))
      else $error("accepted request did not reach update");

   // a new result appears only from an update step
   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_UPDATE))
      else $error("result raised without an update");
`endif

endmodule
